### rtl/core/fnb_pkg.sv
// fnb_pkg: shared widths, constants, register indexes and reset values for the filtered
// noise burst unit. Used by fnb_divider and filtered_noise_burst_unit; depends on nothing.
`default_nettype none

package fnb_pkg;

   // field widths
   localparam int IDX_W       = 14;
   localparam int GEN_W       = 32;
   localparam int ALPHA_W     = 9;
   localparam int AMP_W       = 7;
   localparam int SAMPLE_W    = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_SEED   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_START  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_END    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BURST_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_START_OFFSET = 3'd5;

   // buffer index saturates here; samples at this index always pass through
   localparam logic [IDX_W-1:0] INDEX_MAX = 14'd16383;

   // linear congruential generator
   localparam logic [GEN_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [GEN_W-1:0] LCG_INC = 32'd1013904223;

   // envelope and gain constants
   localparam logic [IDX_W-1:0] ATTACK_LEN = 14'd24;
   localparam logic [IDX_W-1:0] FADE_LEN   = 14'd120;
   localparam logic [IDX_W-1:0] GAIN_DEN   = 14'd127;
   localparam logic [IDX_W-1:0] ENV_DEN    = 14'd255;
   localparam logic [7:0]       ENV_FULL   = 8'd255;

   // serial divider: magnitude bits, divisor bits, quotient bits per cycle
   localparam int DIV_NUM_W          = 24;
   localparam int DIV_DEN_W          = IDX_W;
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_STEPS          = DIV_NUM_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

   // register reset values
   localparam logic [GEN_W-1:0]   RST_NOISE_SEED   = 32'd324508639;
   localparam logic [ALPHA_W-1:0] RST_ALPHA_START  = 9'd150;
   localparam logic [ALPHA_W-1:0] RST_ALPHA_END    = 9'd30;
   localparam logic [AMP_W-1:0]   RST_AMPLITUDE    = 7'd100;
   localparam logic [IDX_W-1:0]   RST_BURST_LENGTH = 14'd1600;
   localparam logic [IDX_W-1:0]   RST_START_OFFSET = 14'd0;

endpackage : fnb_pkg

`default_nettype wire

### rtl/core/fnb_divider.sv
// fnb_divider: signed-by-unsigned serial divider, truncating toward zero,
// two quotient bits per cycle. Depends on fnb_pkg.
`default_nettype none

module fnb_divider
   import fnb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        div_start,
   input  logic signed [DIV_NUM_W:0]   div_num,
   input  logic        [DIV_DEN_W-1:0] div_den,
   output logic                        div_done,
   output logic signed [DIV_NUM_W:0]   div_quo
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] dvd_ff, dvd_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;

   logic [DIV_NUM_W-1:0] num_mag;
   logic [DIV_NUM_W-1:0] dvd_v;
   logic [DIV_DEN_W:0]   rem_v;
   logic [DIV_DEN_W:0]   trial;

   // magnitude of the dividend
   assign num_mag = div_num[DIV_NUM_W] ? DIV_NUM_W'(-div_num) : div_num[DIV_NUM_W-1:0];

   // restoring steps for one cycle
   always_comb begin
      dvd_v = dvd_ff;
      rem_v = rem_ff;
      trial = '0;
      for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
         trial = {rem_v[DIV_DEN_W-1:0], dvd_v[DIV_NUM_W-1]};
         dvd_v = {dvd_v[DIV_NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial    = trial - {1'b0, den_ff};
            dvd_v[0] = 1'b1;
         end
         rem_v = trial;
      end
   end

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = div_num[DIV_NUM_W];
         den_in  = div_den;
         dvd_in  = num_mag;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign div_done = done_ff;
   assign div_quo  = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});

endmodule : fnb_divider

`default_nettype wire

### rtl/core/filtered_noise_burst_unit.sv
// filtered_noise_burst_unit: top level; LCG noise, one-pole lowpass and envelope
// mixed onto a sample stream. Depends on fnb_pkg and fnb_divider.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_base_sample, req_last_item
//   rsp       out        rsp_valid / rsp_stall  rsp_mixed_sample, rsp_last_out
//   csr       in         csr_write_en           csr_index, csr_write_data
//
// A sample outside the burst skips the arithmetic; a burst sample is computed on one
// shared 33x22 multiplier and one serial divider that yields two quotient bits per
// cycle (4 to 6 divisions per burst sample).
// Reset is synchronous and loads the register defaults; no clearing pass.
// A finished beat waits in the output register; the next req beat is taken meanwhile.
`default_nettype none

module filtered_noise_burst_unit
   import fnb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_W-1:0]    req_base_sample,
   input  logic                          req_last_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_W-1:0]    rsp_mixed_sample,
   output logic                          rsp_last_out,
   input  logic                          csr_write_en,
   input  logic        [CSR_INDEX_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LCG_MUL,
      ST_LCG_ADD,
      ST_ALPHA_MUL,
      ST_ALPHA_DIV,
      ST_LP_MUL,
      ST_LP_ADD,
      ST_ENV_MUL,
      ST_ENV_DIV,
      ST_SQ_MUL,
      ST_SQ_DIV,
      ST_FADE_MUL,
      ST_FADE_DIV,
      ST_GAIN_MUL,
      ST_GAIN_DIV,
      ST_SHAPE_MUL,
      ST_SHAPE_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [GEN_W-1:0]   seed_ff, seed_in;
   logic [ALPHA_W-1:0] as_ff, as_in;
   logic [ALPHA_W-1:0] ae_ff, ae_in;
   logic [AMP_W-1:0]   amp_ff, amp_in;
   logic [IDX_W-1:0]   bl_ff, bl_in;
   logic [IDX_W-1:0]   so_ff, so_in;

   // running state
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [GEN_W-1:0]          gen_ff, gen_in;
   logic signed [ALPHA_W-1:0] fv_ff, fv_in;

   // per-sample working registers
   logic signed [SAMPLE_W-1:0] base_ff, base_in;
   logic                       last_ff, last_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic signed [SAMPLE_W-1:0] noise_ff, noise_in;
   logic [ALPHA_W-1:0]         alpha_ff, alpha_in;
   logic [7:0]                 env_ff, env_in;
   logic signed [9:0]          gq_ff, gq_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic signed [54:0]         prod_ff, prod_in;
   logic                       launched_ff, launched_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   // shared units
   logic signed [32:0]          mul_a;
   logic signed [21:0]          mul_b;
   logic                        div_start;
   logic        [DIV_DEN_W-1:0] div_den;
   logic                        div_done;
   logic signed [DIV_NUM_W:0]   div_quo;

   // helpers
   logic                  in_burst;
   logic                  attack;
   logic                  fade;
   logic                  out_free;
   logic                  div_fire;
   logic [GEN_W-1:0]      gen_next;
   logic signed [10:0]    alpha_span;
   logic signed [10:0]    lp_diff;
   logic signed [24:0]    lp_prod;
   logic signed [24:0]    lp_adj;
   logic signed [17:0]    lp_sum;
   logic signed [25:0]    alpha_full;
   logic signed [10:0]    mix;

   fnb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (prod_ff[DIV_NUM_W:0]),
      .div_den   (div_den),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   // sample classification
   assign in_burst = (idx_ff != INDEX_MAX) && (idx_ff >= so_ff) && ((idx_ff - so_ff) < bl_ff);
   assign attack   = i_ff < ATTACK_LEN;
   assign fade     = ({1'b0, i_ff} + {1'b0, FADE_LEN}) > {1'b0, bl_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_fire = launched_ff && div_done;

   // arithmetic around the shared units
   assign gen_next   = prod_ff[GEN_W-1:0] + LCG_INC;
   assign alpha_span = $signed({2'b00, as_ff}) - $signed({2'b00, ae_ff});
   assign lp_diff    = 11'(noise_ff) - 11'(fv_ff);
   assign lp_prod    = prod_ff[24:0];
   assign lp_adj     = lp_prod + (lp_prod[24] ? 25'sd255 : 25'sd0);
   assign lp_sum     = 18'(fv_ff) + 18'($signed(lp_adj[24:8]));
   assign alpha_full = $signed({17'b0, as_ff}) - 26'(div_quo);
   assign mix        = 11'(base_ff) + 11'($signed(div_quo[9:0]));

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LCG_MUL: begin
            mul_a = $signed({1'b0, gen_ff});
            mul_b = $signed(22'(LCG_MUL));
         end
         ST_ALPHA_MUL: begin
            mul_a = 33'(alpha_span);
            mul_b = $signed({8'b0, i_ff});
         end
         ST_LP_MUL: begin
            mul_a = 33'(lp_diff);
            mul_b = $signed({13'b0, alpha_ff});
         end
         ST_ENV_MUL: begin
            mul_a = attack ? $signed({19'b0, i_ff}) : $signed({19'b0, i_ff - ATTACK_LEN});
            mul_b = $signed({14'b0, ENV_FULL});
         end
         ST_SQ_MUL: begin
            mul_a = $signed({25'b0, env_ff});
            mul_b = $signed({14'b0, env_ff});
         end
         ST_FADE_MUL: begin
            mul_a = $signed({25'b0, env_ff});
            mul_b = $signed({8'b0, bl_ff - i_ff});
         end
         ST_GAIN_MUL: begin
            mul_a = 33'(fv_ff);
            mul_b = $signed({15'b0, amp_ff});
         end
         ST_SHAPE_MUL: begin
            mul_a = 33'(gq_ff);
            mul_b = $signed({14'b0, env_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divisor selection
   always_comb begin
      case (state_ff)
         ST_ALPHA_DIV: div_den = bl_ff;
         ST_ENV_DIV:   div_den = attack ? ATTACK_LEN : bl_ff - ATTACK_LEN;
         ST_SQ_DIV:    div_den = ENV_DEN;
         ST_FADE_DIV:  div_den = FADE_LEN;
         ST_GAIN_DIV:  div_den = GAIN_DEN;
         ST_SHAPE_DIV: div_den = ENV_DEN;
         default:      div_den = ENV_DEN;
      endcase
   end

   // sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      seed_in       = seed_ff;
      as_in         = as_ff;
      ae_in         = ae_ff;
      amp_in        = amp_ff;
      bl_in         = bl_ff;
      so_in         = so_ff;
      idx_in        = idx_ff;
      gen_in        = gen_ff;
      fv_in         = fv_ff;
      base_in       = base_ff;
      last_in       = last_ff;
      i_in          = i_ff;
      noise_in      = noise_ff;
      alpha_in      = alpha_ff;
      env_in        = env_ff;
      gq_in         = gq_ff;
      res_in        = res_ff;
      prod_in       = prod_ff;
      launched_in   = launched_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            REG_NOISE_SEED:   seed_in = csr_write_data;
            REG_ALPHA_START:  as_in   = csr_write_data[ALPHA_W-1:0];
            REG_ALPHA_END:    ae_in   = csr_write_data[ALPHA_W-1:0];
            REG_AMPLITUDE:    amp_in  = csr_write_data[AMP_W-1:0];
            REG_BURST_LENGTH: bl_in   = csr_write_data[IDX_W-1:0];
            REG_START_OFFSET: so_in   = csr_write_data[IDX_W-1:0];
            default: ;
         endcase
      end

      // output beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // launch a division on the first cycle of a divide state
      case (state_ff)
         ST_ALPHA_DIV, ST_ENV_DIV, ST_SQ_DIV, ST_FADE_DIV, ST_GAIN_DIV, ST_SHAPE_DIV: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
            end
         end
         default: ;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               base_in = req_base_sample;
               last_in = req_last_item;
               res_in  = req_base_sample;
               i_in    = idx_ff - so_ff;
               if (idx_ff == '0) begin
                  gen_in = seed_ff;
                  fv_in  = '0;
               end
               if (req_last_item) begin
                  idx_in = '0;
               end else if (idx_ff != INDEX_MAX) begin
                  idx_in = idx_ff + 1'b1;
               end
               state_in = in_burst ? ST_LCG_MUL : ST_DONE;
            end
         end
         ST_LCG_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_LCG_ADD;
         end
         ST_LCG_ADD: begin
            // noise is generator bits 23..16 less 128
            gen_in   = gen_next;
            noise_in = $signed({~gen_next[23], gen_next[22:16]});
            state_in = ST_ALPHA_MUL;
         end
         ST_ALPHA_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_ALPHA_DIV;
         end
         ST_ALPHA_DIV: begin
            if (div_fire) begin
               alpha_in = alpha_full[ALPHA_W-1:0];
               state_in = ST_LP_MUL;
            end
         end
         ST_LP_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_LP_ADD;
         end
         ST_LP_ADD: begin
            // divide by 256 toward zero, then saturate to 9 bits
            if (lp_sum > 18'sd255) begin
               fv_in = 9'sd255;
            end else if (lp_sum < -18'sd256) begin
               fv_in = -9'sd256;
            end else begin
               fv_in = lp_sum[ALPHA_W-1:0];
            end
            state_in = ST_ENV_MUL;
         end
         ST_ENV_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_ENV_DIV;
         end
         ST_ENV_DIV: begin
            if (div_fire) begin
               if (attack) begin
                  env_in   = div_quo[7:0];
                  state_in = fade ? ST_FADE_MUL : ST_GAIN_MUL;
               end else begin
                  env_in   = ENV_FULL - div_quo[7:0];
                  state_in = ST_SQ_MUL;
               end
            end
         end
         ST_SQ_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_SQ_DIV;
         end
         ST_SQ_DIV: begin
            if (div_fire) begin
               env_in   = div_quo[7:0];
               state_in = fade ? ST_FADE_MUL : ST_GAIN_MUL;
            end
         end
         ST_FADE_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_FADE_DIV;
         end
         ST_FADE_DIV: begin
            if (div_fire) begin
               env_in   = div_quo[7:0];
               state_in = ST_GAIN_MUL;
            end
         end
         ST_GAIN_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_GAIN_DIV;
         end
         ST_GAIN_DIV: begin
            if (div_fire) begin
               gq_in    = div_quo[9:0];
               state_in = ST_SHAPE_MUL;
            end
         end
         ST_SHAPE_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_SHAPE_DIV;
         end
         ST_SHAPE_DIV: begin
            // mix and clamp to +-127
            if (div_fire) begin
               if (mix > 11'sd127) begin
                  res_in = 8'sd127;
               end else if (mix < -11'sd127) begin
                  res_in = -8'sd127;
               end else begin
                  res_in = mix[SAMPLE_W-1:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= RST_NOISE_SEED;
         as_ff        <= RST_ALPHA_START;
         ae_ff        <= RST_ALPHA_END;
         amp_ff       <= RST_AMPLITUDE;
         bl_ff        <= RST_BURST_LENGTH;
         so_ff        <= RST_START_OFFSET;
         idx_ff       <= '0;
         gen_ff       <= RST_NOISE_SEED;
         fv_ff        <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         as_ff        <= as_in;
         ae_ff        <= ae_in;
         amp_ff       <= amp_in;
         bl_ff        <= bl_in;
         so_ff        <= so_in;
         idx_ff       <= idx_in;
         gen_ff       <= gen_in;
         fv_ff        <= fv_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff       <= base_in;
      last_ff       <= last_in;
      i_ff          <= i_in;
      noise_ff      <= noise_in;
      alpha_ff      <= alpha_in;
      env_ff        <= env_in;
      gq_ff         <= gq_in;
      res_ff        <= res_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule : filtered_noise_burst_unit

`default_nettype wire
